### rtl/u8d_pkg.sv
// Shared types, constants and the minimum-value table of the UTF-8 stream decoder.
package u8d_pkg;

    localparam int CP_W = 31;

    localparam logic [CP_W-1:0] STRICT_MAX   = 31'h0010_FFFF;
    localparam logic [CP_W-1:0] SURR_LO      = 31'h0000_D800;
    localparam logic [CP_W-1:0] SURR_HI      = 31'h0000_DFFF;
    localparam logic            STRICT_RESET = 1'b1;

    // One classified input byte as it travels from the front end to the back end.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       is_ascii;
        logic       is_cont;
        logic       is_reject;
        logic [2:0] lead_len;
        logic [4:0] lead_bits;
        logic       last;
    } t_token;

    // One decoded result.
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            invalid;
    } t_result;

    // Smallest value that a sequence with the given number of continuation
    // bytes may legally encode. Lengths that cannot occur reject everything.
    function automatic logic [31:0] min_value(input logic [2:0] len);
        logic [31:0] v;
        unique case (len)
            3'd1:    v = 32'h0000_0080;
            3'd2:    v = 32'h0000_0800;
            3'd3:    v = 32'h0001_0000;
            3'd4:    v = 32'h0020_0000;
            3'd5:    v = 32'h0400_0000;
            default: v = 32'hFFFF_FFFF;
        endcase
        return v;
    endfunction

endpackage

### rtl/utf8_stream_decoder.sv
// Top level of the streaming UTF-8 decoder with its queue-style ports.
//
// The decoder takes one text byte per transaction on the input queue: a byte is
// taken at a rising clock edge with push high and full low. It decodes extended
// UTF-8 of up to six bytes and produces one result transaction per finished or
// rejected sequence on the output queue. The oldest result sits on
// o_code_point and o_invalid while empty is low and leaves at an edge with pop
// high. A byte that only continues an open sequence produces no result.
//
// A byte that ends its sequence is registered in the token queue, decoded by
// the combinational back end and registered again in the result queue.
// Throughput is one byte per clock while the result queue has room: the decode
// loop in the back end updates its sequence state once per token, and a queue
// that is not full takes and gives a transaction in the same cycle. When the
// receiver stops popping, the result queue fills, the back end stops draining
// tokens, and full rises once the token queue has filled too; nothing is lost.
// Strict mode is set by a transaction on the configuration channel, which is
// always ready, and should change only while the decoder is idle. Synchronous
// reset empties both queues, closes any open sequence and turns strict mode on.
module utf8_stream_decoder #(
    parameter int RES_DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic [7:0]               i_text_byte,
    input  logic                     i_end_of_text,
    output logic                     empty,
    input  logic                     pop,
    output logic [u8d_pkg::CP_W-1:0] o_code_point,
    output logic                     o_invalid,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic                     i_cfg_strict_mode
);
    import u8d_pkg::*;

    logic    r_strict_mode;
    t_token  token;
    logic    tok_empty, tok_pop;
    logic    res_push, res_full;
    t_result res_in, res_out;

    // The strict flag is the only configuration register.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strict_mode <= STRICT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_strict_mode <= i_cfg_strict_mode;
        end
    end

    // Front end classifies bytes and queues them as tokens.
    u8d_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_full        (full),
        .i_tok_pop     (tok_pop),
        .o_token       (token),
        .o_tok_empty   (tok_empty)
    );

    // Back end runs the sequence state and produces results whenever the
    // result queue has room.
    u8d_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_strict_mode (r_strict_mode),
        .i_tok_valid   (!tok_empty),
        .i_token       (token),
        .i_res_room    (!res_full),
        .o_tok_pop     (tok_pop),
        .o_res_push    (res_push),
        .o_result      (res_in)
    );

    // Result queue keeps the decode loop running while the receiver stalls.
    u8d_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_rdata (res_out),
        .o_empty (empty)
    );

    assign o_code_point = res_out.code_point;
    assign o_invalid    = res_out.invalid;

    // The back end must never hand a result to a full result queue.
    a_no_res_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(res_push && res_full))
        else $error("result pushed into a full queue");

    // A token is consumed only when one is present.
    a_no_tok_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(tok_pop && tok_empty))
        else $error("token popped from an empty queue");

    // Rejected sequences always carry a zero code point.
    a_invalid_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_invalid) |-> (o_code_point == '0))
        else $error("invalid result with nonzero code point");

    // Reset leaves the result side empty.
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

endmodule

### rtl/u8d_fifo.sv
// Small first-in first-out queue built from registers.
module u8d_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push_ok, pop_ok;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

### rtl/u8d_front.sv
// Front end: classifies each incoming byte into a decode token.
module u8d_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  logic [7:0]      i_text_byte,
    input  logic            i_end_of_text,
    output logic            o_full,
    input  logic            i_tok_pop,
    output u8d_pkg::t_token o_token,
    output logic            o_tok_empty
);
    import u8d_pkg::*;

    t_token tok;
    logic [7:0] b;

    assign b = i_text_byte;

    always_comb begin
        tok           = '0;
        tok.text_byte = b;
        tok.last      = i_end_of_text;
        tok.is_ascii  = !b[7];
        tok.is_cont   = (b[7:6] == 2'b10);
        tok.is_reject = (b[7:1] == 7'b1111111);
        priority if (b < 8'hE0) begin
            tok.lead_len  = 3'd1;
            tok.lead_bits = b[4:0];
        end else if (b < 8'hF0) begin
            tok.lead_len  = 3'd2;
            tok.lead_bits = {1'b0, b[3:0]};
        end else if (b < 8'hF8) begin
            tok.lead_len  = 3'd3;
            tok.lead_bits = {2'b0, b[2:0]};
        end else if (b < 8'hFC) begin
            tok.lead_len  = 3'd4;
            tok.lead_bits = {3'b0, b[1:0]};
        end else begin
            tok.lead_len  = 3'd5;
            tok.lead_bits = {4'b0, b[0]};
        end
    end

    // Token queue that decouples the byte source from the decode loop.
    u8d_fifo #(
        .WIDTH ($bits(t_token)),
        .DEPTH (4)
    ) u_tok_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_wdata (tok),
        .o_full  (o_full),
        .i_pop   (i_tok_pop),
        .o_rdata (o_token),
        .o_empty (o_tok_empty)
    );

endmodule

### rtl/u8d_back.sv
// Back end: sequence state, payload assembly and validity checks.
module u8d_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_strict_mode,
    input  logic             i_tok_valid,
    input  u8d_pkg::t_token  i_token,
    input  logic             i_res_room,
    output logic             o_tok_pop,
    output logic             o_res_push,
    output u8d_pkg::t_result o_result
);
    import u8d_pkg::*;

    logic [2:0]      r_bytes_left, n_bytes_left;
    logic [2:0]      r_seq_length, n_seq_length;
    logic [CP_W-1:0] r_partial, n_partial;
    logic [CP_W-1:0] shifted;
    logic [2:0]      left_dec;
    logic            take, emit, bad;
    t_result         res;

    assign take     = i_tok_valid && i_res_room;
    assign shifted  = {r_partial[CP_W-7:0], i_token.text_byte[5:0]};
    assign left_dec = r_bytes_left - 3'd1;

    always_comb begin
        n_bytes_left = r_bytes_left;
        n_seq_length = r_seq_length;
        n_partial    = r_partial;
        emit         = 1'b0;
        res          = '0;
        bad          = 1'b0;
        if (r_bytes_left == 3'd0) begin
            priority if (i_token.is_ascii) begin
                emit           = 1'b1;
                res.code_point = {24'b0, i_token.text_byte[6:0]};
            end else if (i_token.is_cont || i_token.is_reject || i_token.last) begin
                emit        = 1'b1;
                res.invalid = 1'b1;
            end else begin
                n_bytes_left = i_token.lead_len;
                n_seq_length = i_token.lead_len;
                n_partial    = {26'b0, i_token.lead_bits};
            end
        end else if (!i_token.is_cont) begin
            emit         = 1'b1;
            res.invalid  = 1'b1;
            n_bytes_left = '0;
            n_seq_length = '0;
            n_partial    = '0;
        end else begin
            priority if (left_dec == 3'd0) begin
                bad = ({1'b0, shifted} < min_value(r_seq_length))
                    || (i_strict_mode && ((shifted > STRICT_MAX)
                        || ((shifted >= SURR_LO) && (shifted <= SURR_HI))));
                emit           = 1'b1;
                res.invalid    = bad;
                res.code_point = bad ? '0 : shifted;
                n_bytes_left   = '0;
                n_seq_length   = '0;
                n_partial      = '0;
            end else if (i_token.last) begin
                emit         = 1'b1;
                res.invalid  = 1'b1;
                n_bytes_left = '0;
                n_seq_length = '0;
                n_partial    = '0;
            end else begin
                n_bytes_left = left_dec;
                n_partial    = shifted;
            end
        end
    end

    assign o_tok_pop  = take;
    assign o_res_push = take && emit;
    assign o_result   = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= '0;
            r_seq_length <= '0;
            r_partial    <= '0;
        end else if (take) begin
            r_bytes_left <= n_bytes_left;
            r_seq_length <= n_seq_length;
            r_partial    <= n_partial;
        end
    end

endmodule

### bench/utf8_stream_decoder_tb.sv
// Self-checking testbench for the streaming UTF-8 decoder, with directed and random text.
module utf8_stream_decoder_tb;
    import u8d_pkg::*;

    // The limit is kept far above the slowest correct run so that only a hang
    // or a lost transaction can reach it.
    localparam int CYCLE_LIMIT  = 200000;
    // This pause lets any byte that gives no result finish inside the block first.
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_BYTES = 250;
    localparam int MODE_STRETCH = 50;

    typedef logic [7:0] t_bytes [$];

    // Every input of the block is driven to a known value from time zero.
    logic               i_clk             = 1'b0;
    logic               i_rst_n           = 1'b0;
    logic               push              = 1'b0;
    logic               full;
    logic [7:0]         i_text_byte       = 8'h00;
    logic               i_end_of_text     = 1'b0;
    logic               empty;
    logic               pop               = 1'b0;
    logic [CP_W-1:0]    o_code_point;
    logic               o_invalid;
    logic               i_cfg_valid       = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_strict_mode = 1'b1;

    // Decoder state as the bench predicts it, mirrored outside the block.
    logic [2:0]         dec_left     = 3'd0;
    logic [2:0]         dec_len      = 3'd0;
    logic [CP_W-1:0]    dec_acc      = '0;
    logic               strict_model = STRICT_RESET;

    // Results that the predictor expects, oldest first.
    t_result            pending_cps [$];

    // Idling controls. The sender draws a gap before every byte and the
    // receiver a stall after every result while these are set.
    bit                 tx_gap_en   = 1'b0;
    bit                 rx_stall_en = 1'b0;
    int                 pop_wait    = 0;

    int                 err_count    = 0;
    int                 cycle_count  = 0;
    int                 n_bytes      = 0;
    int                 n_results    = 0;
    int                 n_invalid    = 0;
    int                 n_cfg_writes = 0;

    utf8_stream_decoder u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_text_byte       (i_text_byte),
        .i_end_of_text     (i_end_of_text),
        .empty             (empty),
        .pop               (pop),
        .o_code_point      (o_code_point),
        .o_invalid         (o_invalid),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_strict_mode (i_cfg_strict_mode)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // The watchdog. A run that is still going at the limit has lost a
    // transaction somewhere, so it ends as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[utf8_stream_decoder] ERROR");
            $finish;
        end
    end

    // Predicts the effect of one accepted byte. A byte that opens or continues
    // a sequence only updates the mirrored state. Anything else, including a
    // finished, broken or cut off sequence, queues exactly one result.
    function automatic void decode_byte(input logic [7:0] b, input logic last);
        t_result     r;
        logic [2:0]  n;
        logic [31:0] floor_cp;
        bit          produced;
        r        = '0;
        n        = 3'd0;
        floor_cp = '1;
        produced = 1'b0;
        if (dec_left == 3'd0) begin
            if (b[7] == 1'b0) begin
                // Plain ASCII is valid in either mode.
                r.code_point = {{(CP_W-8){1'b0}}, b};
                produced     = 1'b1;
            end else if (b[7:6] == 2'b10 || b >= 8'hFE) begin
                // A bare continuation byte or an impossible lead byte.
                r.invalid = 1'b1;
                produced  = 1'b1;
            end else begin
                if (b < 8'hE0)      n = 3'd1;
                else if (b < 8'hF0) n = 3'd2;
                else if (b < 8'hF8) n = 3'd3;
                else if (b < 8'hFC) n = 3'd4;
                else                n = 3'd5;
                if (last) begin
                    // The text ends right on a lead byte.
                    r.invalid = 1'b1;
                    produced  = 1'b1;
                end else begin
                    dec_left = n;
                    dec_len  = n;
                    dec_acc  = {{(CP_W-8){1'b0}}, b} & ((31'd1 << (6 - n)) - 31'd1);
                end
            end
        end else if (b[7:6] != 2'b10) begin
            // A malformed continuation closes the sequence and is dropped.
            dec_left  = 3'd0;
            dec_len   = 3'd0;
            dec_acc   = '0;
            r.invalid = 1'b1;
            produced  = 1'b1;
        end else begin
            dec_acc  = {dec_acc[CP_W-7:0], b[5:0]};
            dec_left = dec_left - 3'd1;
            if (dec_left == 3'd0) begin
                case (dec_len)
                    3'd1:    floor_cp = 32'h0000_0080;
                    3'd2:    floor_cp = 32'h0000_0800;
                    3'd3:    floor_cp = 32'h0001_0000;
                    3'd4:    floor_cp = 32'h0020_0000;
                    3'd5:    floor_cp = 32'h0400_0000;
                    default: floor_cp = 32'hFFFF_FFFF;
                endcase
                r.invalid = ({1'b0, dec_acc} < floor_cp) ||
                            (strict_model && (dec_acc > STRICT_MAX ||
                             (dec_acc >= SURR_LO && dec_acc <= SURR_HI)));
                r.code_point = r.invalid ? '0 : dec_acc;
                produced     = 1'b1;
                dec_len      = 3'd0;
                dec_acc      = '0;
            end else if (last) begin
                // The text ends with the sequence still open.
                dec_left  = 3'd0;
                dec_len   = 3'd0;
                dec_acc   = '0;
                r.invalid = 1'b1;
                produced  = 1'b1;
            end
        end
        if (produced)
            pending_cps.push_back(r);
    endfunction

    // The receiver. Each result transaction is compared with the oldest
    // prediction, and then, while stalls are switched on, the next pop may be
    // held back. All of it happens at the clock edge, on values from before it.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (!i_rst_n) begin
            pop      <= 1'b0;
            pop_wait = 0;
        end else if (pop && !empty) begin
            n_results++;
            if (o_invalid)
                n_invalid++;
            if (pending_cps.size() == 0) begin
                $error("result with nothing expected: code_point %h invalid %b",
                       o_code_point, o_invalid);
                err_count++;
            end else begin
                want = pending_cps.pop_front();
                if (o_code_point !== want.code_point) begin
                    $error("code_point: expected %h, got %h", want.code_point, o_code_point);
                    err_count++;
                end
                if (o_invalid !== want.invalid) begin
                    $error("invalid: expected %b, got %b", want.invalid, o_invalid);
                    err_count++;
                end
            end
            pop_wait = rx_stall_en ? $urandom_range(0, 5) : 0;
            pop      <= (pop_wait == 0);
        end else if (!pop) begin
            if (pop_wait > 0)
                pop_wait--;
            if (pop_wait == 0)
                pop <= 1'b1;
        end
    end

    // Sends one byte as an input transaction. Push stays high when the next
    // byte follows at once, so it is never lowered and raised in one step.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = tx_gap_en ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push          <= 1'b1;
        i_text_byte   <= b;
        i_end_of_text <= last;
        do @(posedge i_clk); while (full);
        decode_byte(b, last);
        n_bytes++;
    endtask

    task automatic send_seq(input t_bytes seq, input logic last_on_final);
        for (int k = 0; k < seq.size(); k++)
            send_byte(seq[k], last_on_final && (k == seq.size() - 1));
    endtask

    // Changes strict mode only with the decoder at rest. A closing byte with
    // the end flag first shuts any open sequence, then every result is drained
    // and the DRAIN_CYCLES pause passes before the configuration transaction.
    task automatic set_strict_mode(input logic mode);
        send_byte(8'h0A, 1'b1);
        push <= 1'b0;
        while (pending_cps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid       <= 1'b1;
        i_cfg_strict_mode <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        strict_model = mode;
        i_cfg_valid <= 1'b0;
        n_cfg_writes++;
    endtask

    // Strict mode straight out of reset: ASCII extremes, the bad lead bytes,
    // an overlong form, a surrogate, the largest strict value, a malformed
    // continuation and a sequence cut off by the end flag.
    task automatic test_strict_directed();
        tx_gap_en   = 1'b1;
        rx_stall_en = 1'b1;
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_seq('{8'hC0, 8'h80}, 1'b0);
        send_seq('{8'hDF, 8'hBF}, 1'b0);
        send_seq('{8'hED, 8'hA0, 8'h80}, 1'b0);
        send_seq('{8'hF4, 8'h8F, 8'hBF, 8'hBF}, 1'b0);
        // The 0x41 breaks the sequence and must not come back as a letter.
        send_seq('{8'hE2, 8'h41}, 1'b0);
        send_seq('{8'hE2, 8'h82}, 1'b1);
    endtask

    // With strict mode off, surrogates and values past 0x10FFFF pass, up to
    // the largest six byte value. A lead byte carrying the end flag still fails.
    task automatic test_relaxed_directed();
        tx_gap_en   = 1'b0;
        rx_stall_en = 1'b0;
        set_strict_mode(1'b0);
        send_seq('{8'hED, 8'hA0, 8'h80}, 1'b0);
        send_seq('{8'hF4, 8'h90, 8'h80, 8'h80}, 1'b0);
        send_seq('{8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF}, 1'b0);
        send_byte(8'hC3, 1'b1);
    endtask

    // Random text. Most of it is well-formed sequences of every length with
    // random payload, so that overlong forms, surrogates and out-of-range
    // values come up on their own. The rest is broken sequences and noise.
    // Idling on each side is switched on and off every few dozen bytes.
    task automatic test_random_text(input logic mode);
        int         sent;
        int         next_switch;
        int         kind;
        int         len;
        int         cut;
        int         sel;
        bit         broken;
        bit         trunc;
        logic [7:0] seq [6];
        logic [7:0] junk;
        logic [31:0] r;
        set_strict_mode(mode);
        sent        = 0;
        next_switch = 0;
        while (sent < RANDOM_BYTES) begin
            if (sent >= next_switch) begin
                sel         = $urandom_range(0, 3);
                tx_gap_en   = sel[0];
                rx_stall_en = sel[1];
                next_switch += MODE_STRETCH;
            end
            kind = $urandom_range(0, 99);
            if (kind >= 85) begin
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
                sent++;
            end else begin
                broken = (kind >= 70);
                len    = ($urandom_range(0, 3) == 0 && !broken) ? 1 : $urandom_range(2, 6);
                r      = $urandom;
                case (len)
                    1:       seq[0] = {1'b0, r[6:0]};
                    2:       seq[0] = {3'b110, r[4:0]};
                    3:       seq[0] = {4'b1110, r[3:0]};
                    4:       seq[0] = {5'b11110, r[2:0]};
                    5:       seq[0] = {6'b111110, r[1:0]};
                    default: seq[0] = {7'b1111110, r[0]};
                endcase
                for (int k = 1; k < len; k++) begin
                    r = $urandom;
                    // Now and then the payload sits at its lowest or highest.
                    if (r[9:8] == 2'b00)
                        seq[k] = r[10] ? 8'hBF : 8'h80;
                    else
                        seq[k] = {2'b10, r[5:0]};
                end
                if (!broken) begin
                    for (int k = 0; k < len; k++)
                        send_byte(seq[k], (k == len - 1) && ($urandom_range(0, 9) == 0));
                    sent += len;
                end else begin
                    cut   = $urandom_range(1, len - 1);
                    trunc = 1'($urandom_range(0, 1));
                    for (int k = 0; k < cut; k++)
                        send_byte(seq[k], trunc && (k == cut - 1));
                    sent += cut;
                    if (!trunc) begin
                        junk = 8'($urandom_range(0, 255));
                        if (junk[7:6] == 2'b10)
                            junk[6] = 1'b1;
                        send_byte(junk, $urandom_range(0, 9) == 0);
                        sent++;
                    end
                end
            end
        end
    endtask

    initial begin
        // Synchronous reset, held at the start and never again.
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_strict_directed();
        test_relaxed_directed();
        test_random_text(1'b1);
        test_random_text(1'b0);
        test_random_text(1'b1);
        test_random_text(1'b0);

        // Let every expected result come out, then watch a little longer so
        // that a stray extra result is caught too.
        push <= 1'b0;
        while (pending_cps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d text bytes; checked %0d results, %0d of them flagged invalid.",
                 n_bytes, n_results, n_invalid);
        $display("Strict mode was rewritten %0d times, each setting with and without idling.",
                 n_cfg_writes);
        if (err_count == 0)
            $display("[utf8_stream_decoder] OK");
        else
            $display("[utf8_stream_decoder] ERROR");
        $finish;
    end

endmodule

### utf8_stream_decoder.f
rtl/u8d_pkg.sv
rtl/u8d_fifo.sv
rtl/u8d_front.sv
rtl/u8d_back.sv
rtl/utf8_stream_decoder.sv
bench/utf8_stream_decoder_tb.sv
